FILE: sv/life_grid_generation_engine_unit_defines.svh
// ----------------------------------------------------------------------------
// Life grid engine assertion macros
// Shared concurrent assertion forms: same-cycle and next-cycle implication.
// ----------------------------------------------------------------------------
`ifndef LIFE_GRID_GENERATION_ENGINE_UNIT_DEFINES_SVH
`define LIFE_GRID_GENERATION_ENGINE_UNIT_DEFINES_SVH

// ante holds -> cons holds in the same cycle
`define LGGE_ASSERT_IMPL(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("lgge assertion failed");

// ante holds -> cons holds in the next cycle
`define LGGE_ASSERT_NEXT(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("lgge assertion failed");

`endif

FILE: sv/lgge_pkg.sv
// ----------------------------------------------------------------------------
// lgge_pkg
// Request and register codes, field widths and the B3/S23 cell rule.
// ----------------------------------------------------------------------------
`default_nettype none

package lgge_pkg;

  localparam int REQ_W      = 2;
  localparam int CELL_IDX_W = 9;
  localparam int GENS_W     = 16;
  localparam int DIM_W      = 10;
  localparam int COUNT_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int S_TDATA_W  = 24;
  localparam int S_TUSER_W  = 2;
  localparam int M_TDATA_W  = 40;

  typedef logic [REQ_W-1:0] req_t;
  localparam req_t REQ_WRITE = 2'd0;
  localparam req_t REQ_READ  = 2'd1;
  localparam req_t REQ_RUN   = 2'd2;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_GENS = 2'd0;
  localparam cfg_idx_t CFG_ROWS = 2'd1;
  localparam cfg_idx_t CFG_COLS = 2'd2;

  localparam logic [GENS_W-1:0] GENS_RESET = 16'd100;
  localparam logic [DIM_W-1:0]  DIM_RESET  = 10'd450;

  // live-neighbor count, 0..8
  typedef logic [3:0] nbr_t;

  localparam nbr_t BIRTH_COUNT   = 4'd3;
  localparam nbr_t SURVIVE_COUNT = 4'd2;

  function automatic logic next_alive(input logic self, input nbr_t n);
    next_alive = (n == BIRTH_COUNT) || (self && (n == SURVIVE_COUNT));
  endfunction

endpackage

`default_nettype wire

FILE: sv/lgge_cell_mem.sv
// ----------------------------------------------------------------------------
// lgge_cell_mem
// Row-wide grid store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lgge_cell_mem #(
  parameter int WIDTH = 512,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: sv/lgge_row_evolve.sv
// ----------------------------------------------------------------------------
// lgge_row_evolve
// One lane per column: next state of a row from the rows above and below.
// ----------------------------------------------------------------------------
`default_nettype none

module lgge_row_evolve #(
  parameter int GRID_DIM = 512
) (
  input  logic [GRID_DIM-1:0] up,
  input  logic [GRID_DIM-1:0] mid,
  input  logic [GRID_DIM-1:0] dn,
  input  logic [GRID_DIM-1:0] col_mask,
  output logic [GRID_DIM-1:0] new_row,
  output logic                row_changed
);
  import lgge_pkg::*;

  logic [GRID_DIM+1:0] up_p;
  logic [GRID_DIM+1:0] mid_p;
  logic [GRID_DIM+1:0] dn_p;
  nbr_t                nbr [GRID_DIM];

  // columns past the active width and past either edge read as dead
  always_comb begin
    up_p  = {1'b0, up  & col_mask, 1'b0};
    mid_p = {1'b0, mid & col_mask, 1'b0};
    dn_p  = {1'b0, dn  & col_mask, 1'b0};
    for (int i = 0; i < GRID_DIM; i++) begin
      nbr[i] = nbr_t'(up_p[i]) + nbr_t'(up_p[i+1]) + nbr_t'(up_p[i+2])
             + nbr_t'(mid_p[i]) + nbr_t'(mid_p[i+2])
             + nbr_t'(dn_p[i]) + nbr_t'(dn_p[i+1]) + nbr_t'(dn_p[i+2]);
      // inactive columns keep their stored bit
      new_row[i] = col_mask[i] ? next_alive(mid[i], nbr[i]) : mid[i];
    end
  end

  assign row_changed = |(new_row ^ mid);

endmodule

`default_nettype wire

FILE: sv/life_grid_generation_engine_unit.sv
// ----------------------------------------------------------------------------
// life_grid_generation_engine_unit
// Bounded B3/S23 life grid with cell write, cell read and batch-run requests.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries request beats: s_tuser = req_type, s_tdata = cell_row,
//   cell_col, cell_value. m_* returns one result beat per request:
//   read_alive, generation_total, request_done. cfg_we/cfg_index/cfg_data
//   write generations_per_run, grid_rows, grid_cols; only while idle.
//   The grid sits in a row-wide memory, one grid row per word.
// Request handling (one request at a time):
//   write or read cell: from accept to result load the steps are row fetch,
//     modify or pick bit, result; a read-modify-write of one row word.
//   run: each generation stepped is a row sweep through the memory read port,
//     one row read and one row written back per cycle. A sweep that changes
//     nothing ends the batch early; the counter still grows by the full batch.
//   out-of-grid cell, unknown type, empty run: straight to the result.
// Reset: sync, active high. A clearing pass then writes GRID_DIM zero rows,
//   with s_tready low; config writes are taken throughout.
// Stall: a result waits in the output register; the next request is accepted
//   and worked on meanwhile, its result held until the register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

`include "life_grid_generation_engine_unit_defines.svh"

module life_grid_generation_engine_unit #(
  parameter int GRID_DIM = 512
) (
  input  logic                                clk,
  input  logic                                rst,
  // request channel
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [lgge_pkg::S_TDATA_W-1:0]      s_tdata,  // [8:0] cell_row, [17:9] cell_col,
                                                        // [18] cell_value, [23:19] zero
  input  logic [lgge_pkg::S_TUSER_W-1:0]      s_tuser,  // [1:0] req_type
  // result channel
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [lgge_pkg::M_TDATA_W-1:0]      m_tdata,  // [0] read_alive,
                                                        // [32:1] generation_total,
                                                        // [33] request_done, [39:34] zero
  // configuration write port
  input  logic                                cfg_we,
  input  logic [lgge_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lgge_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import lgge_pkg::*;

  localparam int AW = $clog2(GRID_DIM);
  localparam int CW = $clog2(GRID_DIM + 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH,
    ST_MODIFY,
    ST_GEN,
    ST_RESP
  } state_t;

  state_t state;

  // configuration
  logic [GENS_W-1:0] gens_per_run;
  logic [DIM_W-1:0]  grid_rows;
  logic [DIM_W-1:0]  grid_cols;
  logic [CW-1:0]     rows_act;
  logic [CW-1:0]     cols_act;
  logic [GRID_DIM-1:0] col_mask;

  // request decode
  req_t                  in_type;
  logic [CELL_IDX_W-1:0] in_row;
  logic [CELL_IDX_W-1:0] in_col;
  logic                  in_val;
  logic                  in_inside;
  logic                  run_ok;

  // latched request
  req_t          req_type;
  logic [AW-1:0] req_row;
  logic [AW-1:0] req_col;
  logic          req_val;
  logic          res_alive;
  logic          res_done;
  logic [COUNT_W-1:0] gen_count;

  // clearing pass
  logic [AW-1:0] clr_row;

  // generation sweep
  logic [GENS_W-1:0]   gens_left;
  logic [CW-1:0]       rd_row;
  logic                issue_done;
  logic                issuing;
  logic                rd_live;
  logic                pend_valid;
  logic [CW-1:0]       pend_row;
  logic [CW-1:0]       pend_prev;
  logic                pend_live;
  logic                changed;
  logic [GRID_DIM-1:0] up;
  logic [GRID_DIM-1:0] mid;
  logic [GRID_DIM-1:0] gen_in;
  logic [GRID_DIM-1:0] new_row;
  logic                row_changed;
  logic [GRID_DIM-1:0] cell_bit;

  // memory port
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [GRID_DIM-1:0] mem_wdata;
  logic                mem_re;
  logic [AW-1:0]       mem_raddr;
  logic [GRID_DIM-1:0] rd_data;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      gens_per_run <= GENS_RESET;
      grid_rows    <= DIM_RESET;
      grid_cols    <= DIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GENS: gens_per_run <= cfg_data[GENS_W-1:0];
        CFG_ROWS: grid_rows    <= cfg_data[DIM_W-1:0];
        CFG_COLS: grid_cols    <= cfg_data[DIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // active size is clipped to the store
  always_comb begin
    if (32'(grid_rows) > GRID_DIM) begin
      rows_act = CW'(GRID_DIM);
    end else begin
      rows_act = CW'(grid_rows);
    end
    if (32'(grid_cols) > GRID_DIM) begin
      cols_act = CW'(GRID_DIM);
    end else begin
      cols_act = CW'(grid_cols);
    end
    for (int i = 0; i < GRID_DIM; i++) begin
      col_mask[i] = (i < int'(cols_act));
    end
  end

  // --------------------------------------------------------------------------
  // Request decode
  // --------------------------------------------------------------------------
  assign in_type   = s_tuser[REQ_W-1:0];
  assign in_row    = s_tdata[8:0];
  assign in_col    = s_tdata[17:9];
  assign in_val    = s_tdata[18];
  assign in_inside = (32'(in_row) < 32'(rows_act)) && (32'(in_col) < 32'(cols_act));
  assign run_ok    = (gens_per_run != '0) && (rows_act != '0) && (cols_act != '0);
  assign s_tready  = (state == ST_IDLE);

  // sweep control: reads run two rows ahead of the row being written back
  assign issuing   = !issue_done;
  assign rd_live   = (rd_row < rows_act);
  assign pend_prev = pend_row - 1'b1;
  assign gen_in    = pend_live ? rd_data : '0;   // row past the bottom is dead
  assign cell_bit  = {{(GRID_DIM-1){1'b0}}, 1'b1} << req_col;

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_row    <= '0;
      m_tvalid   <= 1'b0;
      gen_count  <= '0;
      pend_valid <= 1'b0;
      issue_done <= 1'b1;
    end else begin
      // result taken; in ST_RESP the load below decides m_tvalid
      if (m_tvalid && m_tready && (state != ST_RESP)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_row <= clr_row + 1'b1;
          if (clr_row == AW'(GRID_DIM - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            req_type  <= in_type;
            req_row   <= AW'(in_row);
            req_col   <= AW'(in_col);
            req_val   <= in_val;
            res_alive <= 1'b0;
            unique case (in_type)
              REQ_WRITE, REQ_READ: begin
                res_done <= 1'b1;
                state    <= in_inside ? ST_FETCH : ST_RESP;
              end
              REQ_RUN: begin
                res_done   <= 1'b1;
                gen_count  <= gen_count + COUNT_W'(gens_per_run);
                gens_left  <= gens_per_run;
                rd_row     <= '0;
                issue_done <= 1'b0;
                pend_valid <= 1'b0;
                changed    <= 1'b0;
                state      <= run_ok ? ST_GEN : ST_RESP;
              end
              default: begin
                res_done <= 1'b0;
                state    <= ST_RESP;
              end
            endcase
          end
        end
        ST_FETCH: begin
          state <= ST_MODIFY;
        end
        ST_MODIFY: begin
          if (req_type == REQ_READ) begin
            res_alive <= rd_data[req_col];
          end
          state <= ST_RESP;
        end
        ST_GEN: begin
          pend_valid <= issuing;
          if (issuing) begin
            pend_row  <= rd_row;
            pend_live <= rd_live;
            if (rd_row == rows_act) begin
              issue_done <= 1'b1;
            end else begin
              rd_row <= rd_row + 1'b1;
            end
          end
          if (pend_valid) begin
            up  <= (pend_row == '0) ? '0 : mid;
            mid <= gen_in;
            if (pend_row == rows_act) begin
              // end of sweep: next generation only if this one changed a cell
              if ((changed || row_changed) && (gens_left != GENS_W'(1))) begin
                gens_left  <= gens_left - 1'b1;
                rd_row     <= '0;
                issue_done <= 1'b0;
                changed    <= 1'b0;
              end else begin
                state <= ST_RESP;
              end
            end else if (pend_row != '0) begin
              changed <= changed | row_changed;
            end
          end
        end
        ST_RESP: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {6'b0, res_done, gen_count, res_alive};
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Memory port steering
  // --------------------------------------------------------------------------
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_row;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = req_row;
    unique case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_FETCH: begin
        mem_re = 1'b1;
      end
      ST_MODIFY: begin
        if (req_type == REQ_WRITE) begin
          mem_we    = 1'b1;
          mem_waddr = req_row;
          mem_wdata = (rd_data & ~cell_bit) | (req_val ? cell_bit : '0);
        end
      end
      ST_GEN: begin
        mem_re    = issuing && rd_live;
        mem_raddr = rd_row[AW-1:0];
        // in-place write of the row above the one whose read data just arrived
        if (pend_valid && (pend_row != '0)) begin
          mem_we    = 1'b1;
          mem_waddr = pend_prev[AW-1:0];
          mem_wdata = new_row;
        end
      end
      default: begin
      end
    endcase
  end

  lgge_cell_mem #(
    .WIDTH (GRID_DIM),
    .DEPTH (GRID_DIM)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rd_data)
  );

  lgge_row_evolve #(
    .GRID_DIM (GRID_DIM)
  ) u_evolve (
    .up          (up),
    .mid         (mid),
    .dn          (gen_in),
    .col_mask    (col_mask),
    .new_row     (new_row),
    .row_changed (row_changed)
  );

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // sweep never writes back a row it is reading in the same cycle
  `LGGE_ASSERT_IMPL(a_no_rw_clash, clk, rst, mem_we && mem_re, mem_waddr != mem_raddr)
  // sweep writes stay inside the active rows
  `LGGE_ASSERT_IMPL(a_gen_wr_rows, clk, rst, (state == ST_GEN) && mem_we, CW'(mem_waddr) < rows_act)
  // counter moves only on an accepted run beat
  `LGGE_ASSERT_NEXT(a_count_hold, clk, rst, !(s_tvalid && s_tready && (in_type == REQ_RUN)), $stable(gen_count))

endmodule

`default_nettype wire

FILE: tb/sv/life_grid_generation_engine_unit_tb.sv
// ----------------------------------------------------------------------------
// life_grid_generation_engine_unit_tb
// Self-checking bench for the bounded B3/S23 life grid engine. A mirror of the
// grid, the registers and the generation counter predicts every result beat.
// The run covers directed edge cases, large-batch counter steps and random
// phases under several idle and stall mixes.
// ----------------------------------------------------------------------------
`default_nettype none

module life_grid_generation_engine_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lgge_pkg::*;

  localparam int LIFE_DIM = 512;
  localparam req_t REQ_UNKNOWN = 2'd3;   // no request type has this code
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    req_t     kind;
    bit [8:0] row_idx;
    bit [8:0] col_idx;
    bit       value;
  } life_req_t;

  typedef struct packed {
    bit        read_alive;
    bit [31:0] generation_total;
    bit        request_done;
  } life_result_t;

  // --------------------------------------------------------------------------
  // Grid mirror: own copy of cells, registers and counter; queues the result
  // each accepted request should produce and matches returned beats in order.
  // --------------------------------------------------------------------------
  class grid_mirror;
    bit [LIFE_DIM-1:0] cells [LIFE_DIM];
    bit [15:0]         gens_per_run;
    bit [9:0]          rows_reg;
    bit [9:0]          cols_reg;
    bit [31:0]         gen_count;
    life_result_t      awaited_results [$];
    int                mismatches;
    int                results_seen;

    function new();
      foreach (cells[r]) cells[r] = '0;
      gens_per_run = GENS_RESET;
      rows_reg     = DIM_RESET;
      cols_reg     = DIM_RESET;
      gen_count    = '0;
      mismatches   = 0;
      results_seen = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, bit [15:0] data);
      case (idx)
        CFG_GENS: gens_per_run = data;
        CFG_ROWS: rows_reg = data[9:0];
        CFG_COLS: cols_reg = data[9:0];
        default: ;
      endcase
    endfunction

    function int active_dim(bit [9:0] v);
      return (v > LIFE_DIM) ? LIFE_DIM : int'(v);
    endfunction

    function int active_rows();
      return active_dim(rows_reg);
    endfunction

    function int active_cols();
      return active_dim(cols_reg);
    endfunction

    // one generation over the active window; returns 1 if anything changed
    function bit evolve_once(int rows, int cols);
      bit [LIFE_DIM-1:0] nxt [LIFE_DIM];
      bit [LIFE_DIM-1:0] col_mask;
      bit [LIFE_DIM-1:0] band;
      int r0, r1, c0, c1, n;
      bit changed;
      col_mask = '0;
      for (int c = 0; c < cols; c++) col_mask[c] = 1'b1;
      changed = 1'b0;
      for (int r = 0; r < rows; r++) begin
        r0 = (r > 0) ? r - 1 : 0;
        r1 = (r + 1 < rows) ? r + 1 : rows - 1;
        // bits outside the active columns are carried over untouched
        nxt[r] = cells[r] & ~col_mask;
        band = (cells[r0] | cells[r] | cells[r1]) & col_mask;
        if (band != '0) begin
          for (int c = 0; c < cols; c++) begin
            c0 = (c > 0) ? c - 1 : 0;
            c1 = (c + 1 < cols) ? c + 1 : cols - 1;
            n = 0;
            for (int rr = r0; rr <= r1; rr++)
              for (int cc = c0; cc <= c1; cc++)
                n += cells[rr][cc];
            n -= cells[r][c];
            nxt[r][c] = (n == 3) || (cells[r][c] && n == 2);
          end
        end
      end
      for (int r = 0; r < rows; r++) begin
        if (nxt[r] != cells[r]) changed = 1'b1;
        cells[r] = nxt[r];
      end
      return changed;
    endfunction

    function void take_request(life_req_t rq);
      life_result_t want;
      int rows, cols;
      bit in_grid;
      want = '0;
      rows = active_rows();
      cols = active_cols();
      in_grid = (rq.row_idx < rows) && (rq.col_idx < cols);
      case (rq.kind)
        REQ_WRITE: begin
          if (in_grid) cells[rq.row_idx][rq.col_idx] = rq.value;
          want.request_done = 1'b1;
        end
        REQ_READ: begin
          if (in_grid) want.read_alive = cells[rq.row_idx][rq.col_idx];
          want.request_done = 1'b1;
        end
        REQ_RUN: begin
          if (rows > 0 && cols > 0) begin
            // a still generation ends the batch early
            for (int g = 0; g < gens_per_run; g++)
              if (!evolve_once(rows, cols)) break;
          end
          gen_count += gens_per_run;
          want.request_done = 1'b1;
        end
        default: ;
      endcase
      want.generation_total = gen_count;
      awaited_results.push_back(want);
    endfunction

    function void match_result(bit [M_TDATA_W-1:0] beat);
      life_result_t got, want;
      got.read_alive       = beat[0];
      got.generation_total = beat[32:1];
      got.request_done     = beat[33];
      results_seen++;
      if (awaited_results.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("[%0t] result beat with nothing awaited: alive=%0d total=%0d done=%0d",
                   $realtime, got.read_alive, got.generation_total, got.request_done);
        mismatches++;
        return;
      end
      want = awaited_results.pop_front();
      if (got.read_alive != want.read_alive ||
          got.generation_total != want.generation_total ||
          got.request_done != want.request_done) begin
        if (mismatches < MAX_REPORTS)
          $display("[%0t] mismatch alive/total/done: exp %0d/%0d/%0d act %0d/%0d/%0d",
                   $realtime, want.read_alive, want.generation_total, want.request_done,
                   got.read_alive, got.generation_total, got.request_done);
        mismatches++;
      end
    endfunction

    function int outstanding();
      return awaited_results.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT and signals
  // --------------------------------------------------------------------------
  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata;    // [8:0] cell_row, [17:9] cell_col, [18] cell_value
  logic [S_TUSER_W-1:0]  s_tuser;    // [1:0] req_type
  logic                  m_tvalid;
  logic                  m_tready;
  logic [M_TDATA_W-1:0]  m_tdata;    // [0] read_alive, [32:1] generation_total,
                                     // [33] request_done
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  life_grid_generation_engine_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  grid_mirror mirror = new();

  // idle mix knobs, changed per phase by the main sequence
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_cycles    = 0;   // long receiver hold-off, counted down below

  int n_accepted     = 0;
  int n_runs         = 0;
  int n_live_reads   = 0;
  int n_settings     = 0;

  // 8 ns clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // receiver: random stalls, or a long hold-off when one is requested
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        m_tready = 1'b0;
        hold_cycles--;
      end else begin
        m_tready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // beat monitor: requests feed the mirror, results are matched in order
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        mirror.take_request(life_req_t'({s_tuser, s_tdata[8:0], s_tdata[17:9],
                                         s_tdata[18]}));
        n_accepted++;
        if (s_tuser == REQ_RUN) n_runs++;
      end
      if (m_tvalid && m_tready) begin
        if (m_tdata[0]) n_live_reads++;
        mirror.match_result(m_tdata);
      end
    end
  end

  // hard stop well beyond the slowest correct run
  initial begin
    #4_000_000;
    $display("Some tests failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Driver tasks
  // --------------------------------------------------------------------------

  // present one request beat after random gaps, hold it until taken
  task automatic send_request(life_req_t rq);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      s_tvalid = 1'b0;
    end
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tuser  = rq.kind;
    s_tdata  = {5'd0, rq.value, rq.col_idx, rq.row_idx};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_fields(req_t kind, int row_idx, int col_idx, bit value);
    life_req_t rq;
    rq.kind    = kind;
    rq.row_idx = row_idx[8:0];
    rq.col_idx = col_idx[8:0];
    rq.value   = value;
    send_request(rq);
  endtask

  // drop valid, then wait for every awaited result plus a short tail
  task automatic drain();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (mirror.outstanding() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, bit [15:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    mirror.set_reg(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // only called with the block idle
  task automatic configure(bit [15:0] gens, bit [15:0] rows, bit [15:0] cols);
    drain();
    write_reg(CFG_GENS, gens);
    write_reg(CFG_ROWS, rows);
    write_reg(CFG_COLS, cols);
    n_settings++;
  endtask

  // mostly in-grid writes and reads with some runs; the rest is noise
  function automatic life_req_t random_request(int rows, int cols);
    life_req_t rq;
    int pick;
    pick       = $urandom_range(99);
    rq.kind    = REQ_WRITE;
    rq.row_idx = 9'($urandom_range(LIFE_DIM - 1));
    rq.col_idx = 9'($urandom_range(LIFE_DIM - 1));
    rq.value   = 1'($urandom_range(1));
    if (pick < 40) begin
      rq.row_idx = 9'($urandom_range(rows - 1));
      rq.col_idx = 9'($urandom_range(cols - 1));
    end else if (pick < 65) begin
      rq.kind    = REQ_READ;
      rq.row_idx = 9'($urandom_range(rows - 1));
      rq.col_idx = 9'($urandom_range(cols - 1));
    end else if (pick < 77) begin
      rq.kind = REQ_RUN;
    end else if (pick < 87) begin
      rq.kind = REQ_WRITE;          // anywhere, often off the grid
    end else if (pick < 96) begin
      rq.kind = REQ_READ;
    end else begin
      rq.kind = REQ_UNKNOWN;
    end
    return rq;
  endfunction

  // seed a small live cluster, then a random mix over the active grid
  task automatic random_phase(int n_items);
    int rows, cols, r0, c0;
    rows = mirror.active_rows();
    cols = mirror.active_cols();
    r0 = $urandom_range(rows - 3);
    c0 = $urandom_range(cols - 3);
    for (int i = 0; i < 6; i++)
      send_fields(REQ_WRITE, r0 + $urandom_range(2), c0 + $urandom_range(2), 1'b1);
    for (int i = 6; i < n_items; i++)
      send_request(random_request(rows, cols));
  endtask

  task automatic random_setting();
    configure(16'($urandom_range(10)), 16'($urandom_range(3, 24)),
              16'($urandom_range(3, 24)));
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    rst       = 1'b1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset settings: 100 generations on a 450 x 450 grid
    send_fields(REQ_READ, 0, 0, 1'b0);
    send_fields(REQ_WRITE, 0, 0, 1'b1);
    send_fields(REQ_WRITE, 449, 449, 1'b1);
    send_fields(REQ_WRITE, 450, 3, 1'b1);          // off the grid, dropped
    send_fields(REQ_READ, 449, 449, 1'b0);
    send_fields(REQ_UNKNOWN, 300, 511, 1'b1);      // no effect, done low
    send_fields(REQ_RUN, 0, 0, 1'b0);              // lone cells die, then still
    send_fields(REQ_READ, 0, 0, 1'b0);

    // full store, zero-generation run
    configure(16'd0, 16'd512, 16'd512);
    send_fields(REQ_WRITE, 511, 511, 1'b1);
    send_fields(REQ_READ, 511, 511, 1'b0);
    send_fields(REQ_WRITE, 511, 0, 1'b1);
    send_fields(REQ_RUN, 0, 0, 1'b0);
    send_fields(REQ_READ, 511, 0, 1'b0);

    // smallest normal grid: blinker flips, far cells sit outside untouched
    configure(16'd1, 16'd3, 16'd3);
    send_fields(REQ_WRITE, 1, 0, 1'b1);
    send_fields(REQ_WRITE, 1, 1, 1'b1);
    send_fields(REQ_WRITE, 1, 2, 1'b1);
    send_fields(REQ_RUN, 0, 0, 1'b0);
    send_fields(REQ_READ, 0, 1, 1'b0);
    send_fields(REQ_READ, 511, 511, 1'b0);

    // sizes beyond the store clamp to it; kept far cell shows up again
    configure(16'd1, 16'd1023, 16'd600);
    send_fields(REQ_READ, 511, 511, 1'b0);
    send_fields(REQ_RUN, 0, 0, 1'b0);
    send_fields(REQ_READ, 511, 511, 1'b0);

    // zero rows: run only moves the counter
    configure(16'd3, 16'd0, 16'd5);
    send_fields(REQ_RUN, 0, 0, 1'b0);
    send_fields(REQ_READ, 0, 0, 1'b0);

    // sizes below three used as given
    configure(16'd2, 16'd2, 16'd1);
    send_fields(REQ_WRITE, 0, 0, 1'b1);
    send_fields(REQ_WRITE, 1, 0, 1'b1);
    send_fields(REQ_RUN, 0, 0, 1'b0);
    send_fields(REQ_READ, 1, 0, 1'b0);

    // empty-grid runs of the largest batch size move the counter in big steps
    configure(16'hFFFF, 16'd0, 16'd0);
    for (int i = 0; i < 4; i++) send_fields(REQ_RUN, 0, 0, 1'b0);

    // random phases: no idling with a long hold-off first, then the mixes
    random_setting();
    hold_cycles = 400;
    random_phase(18);

    random_setting();
    send_idle_pct = 70;
    random_phase(18);

    random_setting();
    send_idle_pct  = 0;
    recv_stall_pct = 70;
    random_phase(18);

    random_setting();
    send_idle_pct  = 22;
    recv_stall_pct = 22;
    random_phase(18);

    drain();
    repeat (20) @(posedge clk);

    $display("Covered %0d requests (%0d runs, %0d live reads) over %0d register settings,",
             n_accepted, n_runs, n_live_reads, n_settings + 1);
    $display("including large batch steps and a long output hold-off; %0d results checked.",
             mirror.results_seen);
    if (mirror.mismatches == 0 && mirror.outstanding() == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches, %0d results missing", mirror.mismatches,
               mirror.outstanding());
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
